>>> src/dlbs_pkg.sv
// ----------------------------------------------------------------------------
// dlbs_pkg
// Shared constants, types and helpers for the dual LED blink sequencer.
// ----------------------------------------------------------------------------
package dlbs_pkg;

  localparam logic [15:0] MODE_UNDEFINED = 16'hFFFF;
  localparam logic [15:0] MODE_IDLE      = 16'h0000;
  localparam logic [7:0]  BYTE_ON        = 8'h08;
  localparam logic [7:0]  BYTE_OFF       = 8'h00;

  localparam logic [15:0] RESET_LONG_MS  = 16'd8000;
  localparam logic [15:0] RESET_ONCE_MS  = 16'd250;
  localparam logic [15:0] RESET_IDLE_MS  = 16'd250;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LONG_CYCLE = 2'd0,
    CFG_ONCE       = 2'd1,
    CFG_IDLE_POLL  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [15:0] mode;
    logic        external_led;
    logic        onboard_led;
  } dlbs_result_t;

  // drive of one LED from its mode byte
  function automatic logic byte_drive(input logic [7:0] b, input logic on_phase);
    logic d;
    if (b == BYTE_ON) begin
      d = 1'b1;
    end else if (b == BYTE_OFF) begin
      d = 1'b0;
    end else begin
      d = on_phase;
    end
    return d;
  endfunction

  // bit 1 onboard, bit 0 external
  function automatic logic [1:0] mode_drive(input logic [15:0] m, input logic on_phase);
    return {byte_drive(m[15:8], on_phase), byte_drive(m[7:0], on_phase)};
  endfunction

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

>>> src/dlbs_engine.sv
// ----------------------------------------------------------------------------
// dlbs_engine
// Sequencer state, configuration registers and the single-pass step logic.
// ----------------------------------------------------------------------------
module dlbs_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step_en,
  input  dlbs_pkg::opcode_t              opcode,
  input  logic [15:0]                    mode_word,
  input  logic                           cfg_write_en,
  input  logic [dlbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dlbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dlbs_pkg::dlbs_result_t         result
);
  import dlbs_pkg::*;

  logic [15:0] long_cycle_ms;
  logic [15:0] once_ms;
  logic [15:0] idle_poll_ms;

  logic [15:0] current_mode,  current_mode_next;
  logic [15:0] pending_mode,  pending_mode_next;
  logic        pending_valid, pending_valid_next;
  logic        at_boundary,   at_boundary_next;
  logic        phase_on,      phase_on_next;
  logic [15:0] phase_timer,   phase_timer_next;
  logic [15:0] phase_length,  phase_length_next;
  logic [2:0]  cycles_left,   cycles_left_next;
  logic [1:0]  led_drive,     led_drive_next;

  // mode in force once the boundary has consumed the pending slot
  logic [15:0] boundary_mode;
  logic [2:0]  count_hi, count_lo, run_count;
  logic [3:0]  div_hi, div_lo, flash_div;
  logic [15:0] run_length;

  assign boundary_mode = pending_valid ? pending_mode : current_mode;
  assign count_hi  = boundary_mode[10:8];
  assign count_lo  = boundary_mode[2:0];
  assign div_hi    = boundary_mode[15:12];
  assign div_lo    = boundary_mode[7:4];
  assign run_count = (count_hi > count_lo) ? count_hi : count_lo;
  assign flash_div = (div_hi > div_lo) ? div_hi : div_lo;
  assign run_length = at_least_one((flash_div == 4'd0) ? once_ms
                                                       : (long_cycle_ms >> flash_div));

  always_ff @(posedge clk) begin
    if (rst) begin
      long_cycle_ms <= RESET_LONG_MS;
      once_ms       <= RESET_ONCE_MS;
      idle_poll_ms  <= RESET_IDLE_MS;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_LONG_CYCLE: long_cycle_ms <= cfg_data;
        CFG_ONCE:       once_ms       <= cfg_data;
        CFG_IDLE_POLL:  idle_poll_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode  <= MODE_UNDEFINED;
      pending_mode  <= 16'd0;
      pending_valid <= 1'b0;
      at_boundary   <= 1'b1;
      phase_on      <= 1'b0;
      phase_timer   <= 16'd0;
      phase_length  <= 16'd0;
      cycles_left   <= 3'd0;
      led_drive     <= 2'b00;
    end else begin
      current_mode  <= current_mode_next;
      pending_mode  <= pending_mode_next;
      pending_valid <= pending_valid_next;
      at_boundary   <= at_boundary_next;
      phase_on      <= phase_on_next;
      phase_timer   <= phase_timer_next;
      phase_length  <= phase_length_next;
      cycles_left   <= cycles_left_next;
      led_drive     <= led_drive_next;
    end
  end

  always_comb begin
    current_mode_next  = current_mode;
    pending_mode_next  = pending_mode;
    pending_valid_next = pending_valid;
    at_boundary_next   = at_boundary;
    phase_on_next      = phase_on;
    phase_timer_next   = phase_timer;
    phase_length_next  = phase_length;
    cycles_left_next   = cycles_left;
    led_drive_next     = led_drive;

    if (step_en) begin
      if (opcode == OP_REQUEST) begin
        if (mode_word != MODE_UNDEFINED) begin
          pending_mode_next  = mode_word;
          pending_valid_next = 1'b1;
        end
      end else begin
        if (at_boundary) begin
          current_mode_next  = boundary_mode;
          pending_valid_next = 1'b0;
          at_boundary_next   = 1'b0;
          if (boundary_mode == MODE_UNDEFINED) begin
            // idle poll wait, leds keep their drive
            phase_on_next    = 1'b0;
            cycles_left_next = 3'd0;
            phase_timer_next = at_least_one(idle_poll_ms);
          end else begin
            phase_length_next = run_length;
            cycles_left_next  = (run_count == 3'd0) ? 3'd1 : run_count;
            phase_on_next     = 1'b1;
            led_drive_next    = mode_drive(boundary_mode, 1'b1);
            phase_timer_next  = run_length;
          end
        end

        if (phase_timer_next != 16'd0) begin
          phase_timer_next = phase_timer_next - 16'd1;
        end

        if (phase_timer_next == 16'd0) begin
          if (phase_on_next) begin
            phase_on_next    = 1'b0;
            led_drive_next   = mode_drive(current_mode_next, 1'b0);
            phase_timer_next = phase_length_next;
          end else if (cycles_left_next > 3'd1) begin
            cycles_left_next = cycles_left_next - 3'd1;
            phase_on_next    = 1'b1;
            led_drive_next   = mode_drive(current_mode_next, 1'b1);
            phase_timer_next = phase_length_next;
          end else begin
            // counted run falls back to idle
            if (current_mode_next != MODE_UNDEFINED && cycles_left_next != 3'd0 &&
                (current_mode_next[10:8] | current_mode_next[2:0]) != 3'd0) begin
              current_mode_next = MODE_IDLE;
            end
            cycles_left_next = 3'd0;
            at_boundary_next = 1'b1;
          end
        end
      end
    end
  end

  assign result.onboard_led  = led_drive_next[1];
  assign result.external_led = led_drive_next[0];
  assign result.mode         = current_mode_next;

endmodule

>>> src/dual_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// dual_led_blink_sequencer
// Two-LED blink sequencer driven by millisecond ticks and mode requests.
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless the result register stalls; input register, step logic, result register
// a stalled result register holds the pipe, an empty input register still takes one word
// rst (synchronous) clears the pipe, restores the register defaults and
// leaves the mode undefined with both leds off
module dual_led_blink_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] mode_word
  input  logic                             s_axis_tuser,  // [0] opcode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] onboard_led, [1] external_led, [17:2] active_mode, [23:18] zero
  output logic [23:0]                      m_axis_tdata,
  input  logic                             cfg_write_en,
  input  logic [dlbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dlbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dlbs_pkg::*;

  logic         in_valid;
  opcode_t      in_opcode;
  logic [15:0]  in_word;
  logic         advance;
  logic         step;
  dlbs_result_t step_result;
  dlbs_result_t out_word;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode <= opcode_t'(s_axis_tuser);
      in_word   <= s_axis_tdata;
    end
  end

  dlbs_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step),
    .opcode       (in_opcode),
    .mode_word    (in_word),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= step_result;
    end
  end

  assign m_axis_tdata = {6'd0, out_word};

endmodule
